// File: src/handheld_cpu_alu_with_flags_unit_defines.svh
// Assertion macros shared by the checker of the handheld CPU ALU.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef HANDHELD_CPU_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define HANDHELD_CPU_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define HCALU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ALU check failed");

// Next-cycle implication, disabled while reset is low
`define HCALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ALU check failed");

`endif

// File: src/hcalu_pkg.sv
// Operation codes shared by the handheld CPU ALU and its checker.
// No dependencies.
package hcalu_pkg;

    // ALU operation codes; values 29 to 31 are unused
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLC  = 5'd10,
        OP_RRC  = 5'd11,
        OP_RL   = 5'd12,
        OP_RR   = 5'd13,
        OP_SLA  = 5'd14,
        OP_SRA  = 5'd15,
        OP_SWAP = 5'd16,
        OP_SRL  = 5'd17,
        OP_BIT  = 5'd18,
        OP_RES  = 5'd19,
        OP_SET  = 5'd20,
        OP_DAA  = 5'd21,
        OP_CPL  = 5'd22,
        OP_SCF  = 5'd23,
        OP_CCF  = 5'd24,
        OP_RLCA = 5'd25,
        OP_RRCA = 5'd26,
        OP_RLA  = 5'd27,
        OP_RRA  = 5'd28
    } t_op;

    // BCD adjust constants
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

endpackage

// File: src/handheld_cpu_alu_with_flags_unit.sv
// Top level of the handheld CPU 8-bit ALU with Z/N/H/C flags.
// Depends on hcalu_pkg for operation codes and DAA constants.
//
//  channel   | handshake         | fields
//  ----------+-------------------+-----------------------------------------------
//  command   | start / busy      | i_cmd, i_operand_a, i_operand_b, i_bit_index,
//            |                   | i_zero_in, i_subtract_in, i_half_in, i_carry_in
//  result    | o_valid (strobe)  | o_result, o_writes_result, o_zero_out,
//            |                   | o_subtract_out, o_half_out, o_carry_out
//
// One word is taken every cycle; busy stays low. Each word passes first
// through the input register, then through the adder and flag logic into
// the result register, which drives the result ports.
// Reset (synchronous, active low) clears both valid bits; payload is not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module handheld_cpu_alu_with_flags_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] i_cmd,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic [2:0] i_bit_index,
    input  logic       i_zero_in,
    input  logic       i_subtract_in,
    input  logic       i_half_in,
    input  logic       i_carry_in,
    output logic       o_valid,
    output logic [7:0] o_result,
    output logic       o_writes_result,
    output logic       o_zero_out,
    output logic       o_subtract_out,
    output logic       o_half_out,
    output logic       o_carry_out
);

    // input register
    logic       r_in_vld;
    logic [4:0] r_cmd;
    logic [7:0] r_a;
    logic [7:0] r_b;
    logic [2:0] r_bi;
    logic       r_zi;
    logic       r_ni;
    logic       r_hi;
    logic       r_ci;

    // result register
    logic       r_out_vld;
    logic [7:0] r_result;
    logic       r_wr;
    logic       r_z;
    logic       r_n;
    logic       r_h;
    logic       r_c;

    // next result values
    logic [7:0] n_result;
    logic       n_wr;
    logic       n_z;
    logic       n_n;
    logic       n_h;
    logic       n_c;

    // shared datapath
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] diff9;
    logic [4:0] diff_lo;
    logic [7:0] mask;
    logic       daa_hi;
    logic       daa_lo;
    logic [7:0] daa_adj;
    logic [7:0] daa_res;

    assign busy = 1'b0;

    // capture each word as it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_cmd <= i_cmd;
        r_a   <= i_operand_a;
        r_b   <= i_operand_b;
        r_bi  <= i_bit_index;
        r_zi  <= i_zero_in;
        r_ni  <= i_subtract_in;
        r_hi  <= i_half_in;
        r_ci  <= i_carry_in;
    end

    // carry in only for the with-carry forms
    assign cin = r_ci && ((r_cmd == hcalu_pkg::OP_ADC) || (r_cmd == hcalu_pkg::OP_SBC));

    // adder and subtractor with nibble carry and borrow
    assign sum9    = {1'b0, r_a} + {1'b0, r_b} + {8'd0, cin};
    assign sum_lo  = {1'b0, r_a[3:0]} + {1'b0, r_b[3:0]} + {4'd0, cin};
    assign diff9   = {1'b0, r_a} - {1'b0, r_b} - {8'd0, cin};
    assign diff_lo = {1'b0, r_a[3:0]} - {1'b0, r_b[3:0]} - {4'd0, cin};

    // one-hot bit select for bit, res, set
    assign mask = 8'd1 << r_bi;

    // decimal adjust
    assign daa_hi  = r_ni ? r_ci : (r_ci || (r_a > hcalu_pkg::DAA_HI_MAX));
    assign daa_lo  = r_ni ? r_hi : (r_hi || (r_a[3:0] > hcalu_pkg::DAA_LO_MAX));
    assign daa_adj = (daa_hi ? hcalu_pkg::DAA_HI_ADJ : 8'h00)
                   | (daa_lo ? hcalu_pkg::DAA_LO_ADJ : 8'h00);
    assign daa_res = r_ni ? (r_a - daa_adj) : (r_a + daa_adj);

    // select result and flags by operation
    always_comb begin
        n_result = r_a;
        n_wr     = 1'b1;
        n_z      = r_zi;
        n_n      = 1'b0;
        n_h      = 1'b0;
        n_c      = r_ci;
        unique case (hcalu_pkg::t_op'(r_cmd))
            hcalu_pkg::OP_ADD, hcalu_pkg::OP_ADC: begin
                n_result = sum9[7:0];
                n_z      = (sum9[7:0] == 8'd0);
                n_h      = sum_lo[4];
                n_c      = sum9[8];
            end
            hcalu_pkg::OP_SUB, hcalu_pkg::OP_SBC: begin
                n_result = diff9[7:0];
                n_z      = (diff9[7:0] == 8'd0);
                n_n      = 1'b1;
                n_h      = diff_lo[4];
                n_c      = diff9[8];
            end
            hcalu_pkg::OP_CP: begin
                n_wr = 1'b0;
                n_z  = (diff9[7:0] == 8'd0);
                n_n  = 1'b1;
                n_h  = diff_lo[4];
                n_c  = diff9[8];
            end
            hcalu_pkg::OP_AND: begin
                n_result = r_a & r_b;
                n_z      = ((r_a & r_b) == 8'd0);
                n_h      = 1'b1;
                n_c      = 1'b0;
            end
            hcalu_pkg::OP_XOR: begin
                n_result = r_a ^ r_b;
                n_z      = ((r_a ^ r_b) == 8'd0);
                n_c      = 1'b0;
            end
            hcalu_pkg::OP_OR: begin
                n_result = r_a | r_b;
                n_z      = ((r_a | r_b) == 8'd0);
                n_c      = 1'b0;
            end
            hcalu_pkg::OP_INC: begin
                n_result = r_a + 8'd1;
                n_z      = (r_a == 8'hFF);
                n_h      = (r_a[3:0] == 4'hF);
            end
            hcalu_pkg::OP_DEC: begin
                n_result = r_a - 8'd1;
                n_z      = (r_a == 8'h01);
                n_n      = 1'b1;
                n_h      = (r_a[3:0] == 4'h0);
            end
            hcalu_pkg::OP_RLC, hcalu_pkg::OP_RLCA: begin
                n_result = {r_a[6:0], r_a[7]};
                n_z      = (r_cmd == hcalu_pkg::OP_RLC) && (r_a == 8'd0);
                n_c      = r_a[7];
            end
            hcalu_pkg::OP_RRC, hcalu_pkg::OP_RRCA: begin
                n_result = {r_a[0], r_a[7:1]};
                n_z      = (r_cmd == hcalu_pkg::OP_RRC) && (r_a == 8'd0);
                n_c      = r_a[0];
            end
            hcalu_pkg::OP_RL, hcalu_pkg::OP_RLA: begin
                n_result = {r_a[6:0], r_ci};
                n_z      = (r_cmd == hcalu_pkg::OP_RL) && ({r_a[6:0], r_ci} == 8'd0);
                n_c      = r_a[7];
            end
            hcalu_pkg::OP_RR, hcalu_pkg::OP_RRA: begin
                n_result = {r_ci, r_a[7:1]};
                n_z      = (r_cmd == hcalu_pkg::OP_RR) && ({r_ci, r_a[7:1]} == 8'd0);
                n_c      = r_a[0];
            end
            hcalu_pkg::OP_SLA: begin
                n_result = {r_a[6:0], 1'b0};
                n_z      = (r_a[6:0] == 7'd0);
                n_c      = r_a[7];
            end
            hcalu_pkg::OP_SRA: begin
                n_result = {r_a[7], r_a[7:1]};
                n_z      = (r_a == 8'd0) || (r_a == 8'd1);
                n_c      = r_a[0];
            end
            hcalu_pkg::OP_SWAP: begin
                n_result = {r_a[3:0], r_a[7:4]};
                n_z      = (r_a == 8'd0);
                n_c      = 1'b0;
            end
            hcalu_pkg::OP_SRL: begin
                n_result = {1'b0, r_a[7:1]};
                n_z      = (r_a[7:1] == 7'd0);
                n_c      = r_a[0];
            end
            hcalu_pkg::OP_BIT: begin
                n_wr = 1'b0;
                n_z  = ((r_a & mask) == 8'd0);
                n_h  = 1'b1;
            end
            hcalu_pkg::OP_RES: begin
                n_result = r_a & ~mask;
                n_n      = r_ni;
                n_h      = r_hi;
            end
            hcalu_pkg::OP_SET: begin
                n_result = r_a | mask;
                n_n      = r_ni;
                n_h      = r_hi;
            end
            hcalu_pkg::OP_DAA: begin
                n_result = daa_res;
                n_z      = (daa_res == 8'd0);
                n_n      = r_ni;
                n_c      = daa_hi;
            end
            hcalu_pkg::OP_CPL: begin
                n_result = ~r_a;
                n_n      = 1'b1;
                n_h      = 1'b1;
            end
            hcalu_pkg::OP_SCF: begin
                n_wr = 1'b0;
                n_c  = 1'b1;
            end
            hcalu_pkg::OP_CCF: begin
                n_wr = 1'b0;
                n_c  = !r_ci;
            end
            default: begin
                // unused codes pass the operand and all flags through
                n_wr = 1'b0;
                n_n  = r_ni;
                n_h  = r_hi;
            end
        endcase
    end

    // register the finished word and its valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        r_result <= n_result;
        r_wr     <= n_wr;
        r_z      <= n_z;
        r_n      <= n_n;
        r_h      <= n_h;
        r_c      <= n_c;
    end

    assign o_valid         = r_out_vld;
    assign o_result        = r_result;
    assign o_writes_result = r_wr;
    assign o_zero_out      = r_z;
    assign o_subtract_out  = r_n;
    assign o_half_out      = r_h;
    assign o_carry_out     = r_c;

endmodule

// File: src/hcalu_checker.sv
// Port-level checker for the handheld CPU ALU, bound to the top level.
// Depends on hcalu_pkg and handheld_cpu_alu_with_flags_unit_defines.svh.
`include "handheld_cpu_alu_with_flags_unit_defines.svh"

module hcalu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [4:0] i_cmd,
    input logic [7:0] i_operand_a,
    input logic [7:0] i_operand_b,
    input logic [2:0] i_bit_index,
    input logic       i_zero_in,
    input logic       i_subtract_in,
    input logic       i_half_in,
    input logic       i_carry_in,
    input logic       o_valid,
    input logic [7:0] o_result,
    input logic       o_writes_result,
    input logic       o_zero_out,
    input logic       o_subtract_out,
    input logic       o_half_out,
    input logic       o_carry_out
);

    // every taken word comes out after the input and result registers
    `HCALU_ASSERT_NEXT(a_word_out, i_clk, i_rst_n, start && !busy, ##1 o_valid)

    // no result without a word taken ahead of it through both registers
    `HCALU_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_valid, $past(start, 2) && !$past(busy, 2))

    // compare writes nothing and returns the accumulator
    `HCALU_ASSERT_IMPL(a_cp_no_write, i_clk, i_rst_n, o_valid && ($past(i_cmd, 2) == hcalu_pkg::OP_CP), !o_writes_result && o_subtract_out && (o_result == $past(i_operand_a, 2)))

    // set carry forces carry and keeps zero
    `HCALU_ASSERT_IMPL(a_scf_flags, i_clk, i_rst_n, o_valid && ($past(i_cmd, 2) == hcalu_pkg::OP_SCF), o_carry_out && !o_half_out && (o_zero_out == $past(i_zero_in, 2)))

endmodule

bind handheld_cpu_alu_with_flags_unit hcalu_checker u_hcalu_checker (.*);

// File: test/handheld_cpu_alu_with_flags_unit_checker.sv
// Scoreboard for the handheld CPU ALU: predicts the result word of every
// accepted command word and compares it with the strobed output.
// Depends on hcalu_pkg for operation codes and DAA constants.
module handheld_cpu_alu_with_flags_unit_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [4:0] i_cmd,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic [2:0] i_bit_index,
    input  logic       i_zero_in,
    input  logic       i_subtract_in,
    input  logic       i_half_in,
    input  logic       i_carry_in,
    input  logic       i_valid,
    input  logic [7:0] i_result,
    input  logic       i_writes_result,
    input  logic       i_zero_out,
    input  logic       i_subtract_out,
    input  logic       i_half_out,
    input  logic       i_carry_out,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] result;
        logic       wb;
        logic       z;
        logic       n;
        logic       h;
        logic       c;
    } t_alu_word;

    t_alu_word alu_expected_q[$];
    int        mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Compute result byte, write-back mark and new flags of one command word
    function automatic t_alu_word predict_alu(
        input logic [4:0] cmd,
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [2:0] bi,
        input logic       zi,
        input logic       ni,
        input logic       hi,
        input logic       ci
    );
        t_alu_word  w;
        logic [8:0] wide;
        logic [4:0] nib;
        logic [7:0] mask;
        logic [7:0] r;
        logic       cin;
        logic       c;

        mask = 8'h01 << bi;
        w    = '{result: a, wb: 1'b0, z: zi, n: ni, h: hi, c: ci};
        case (cmd)
            hcalu_pkg::OP_ADD, hcalu_pkg::OP_ADC: begin
                cin  = (cmd == hcalu_pkg::OP_ADC) ? ci : 1'b0;
                wide = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                w    = '{wide[7:0], 1'b1, wide[7:0] == 8'd0, 1'b0, nib[4], wide[8]};
            end
            hcalu_pkg::OP_SUB, hcalu_pkg::OP_SBC, hcalu_pkg::OP_CP: begin
                // bit above the top is the borrow
                cin  = (cmd == hcalu_pkg::OP_SBC) ? ci : 1'b0;
                wide = {1'b0, a} - {1'b0, b} - {8'd0, cin};
                nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
                w    = '{wide[7:0], 1'b1, wide[7:0] == 8'd0, 1'b1, nib[4], wide[8]};
                if (cmd == hcalu_pkg::OP_CP) begin
                    w.result = a;
                    w.wb     = 1'b0;
                end
            end
            hcalu_pkg::OP_AND: begin
                r = a & b;
                w = '{r, 1'b1, r == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            hcalu_pkg::OP_XOR: begin
                r = a ^ b;
                w = '{r, 1'b1, r == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            hcalu_pkg::OP_OR: begin
                r = a | b;
                w = '{r, 1'b1, r == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            hcalu_pkg::OP_INC: begin
                r = a + 8'd1;
                w = '{r, 1'b1, r == 8'd0, 1'b0, a[3:0] == 4'hF, ci};
            end
            hcalu_pkg::OP_DEC: begin
                r = a - 8'd1;
                w = '{r, 1'b1, r == 8'd0, 1'b1, a[3:0] == 4'h0, ci};
            end
            hcalu_pkg::OP_RLC, hcalu_pkg::OP_RLCA: begin
                r = {a[6:0], a[7]};
                w = '{r, 1'b1, (cmd == hcalu_pkg::OP_RLC) && (r == 8'd0), 1'b0, 1'b0, a[7]};
            end
            hcalu_pkg::OP_RRC, hcalu_pkg::OP_RRCA: begin
                r = {a[0], a[7:1]};
                w = '{r, 1'b1, (cmd == hcalu_pkg::OP_RRC) && (r == 8'd0), 1'b0, 1'b0, a[0]};
            end
            hcalu_pkg::OP_RL, hcalu_pkg::OP_RLA: begin
                r = {a[6:0], ci};
                w = '{r, 1'b1, (cmd == hcalu_pkg::OP_RL) && (r == 8'd0), 1'b0, 1'b0, a[7]};
            end
            hcalu_pkg::OP_RR, hcalu_pkg::OP_RRA: begin
                r = {ci, a[7:1]};
                w = '{r, 1'b1, (cmd == hcalu_pkg::OP_RR) && (r == 8'd0), 1'b0, 1'b0, a[0]};
            end
            hcalu_pkg::OP_SLA: begin
                r = {a[6:0], 1'b0};
                w = '{r, 1'b1, r == 8'd0, 1'b0, 1'b0, a[7]};
            end
            hcalu_pkg::OP_SRA: begin
                r = {a[7], a[7:1]};
                w = '{r, 1'b1, r == 8'd0, 1'b0, 1'b0, a[0]};
            end
            hcalu_pkg::OP_SWAP: begin
                r = {a[3:0], a[7:4]};
                w = '{r, 1'b1, r == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            hcalu_pkg::OP_SRL: begin
                r = {1'b0, a[7:1]};
                w = '{r, 1'b1, r == 8'd0, 1'b0, 1'b0, a[0]};
            end
            hcalu_pkg::OP_BIT: w = '{a, 1'b0, (a & mask) == 8'd0, 1'b0, 1'b1, ci};
            hcalu_pkg::OP_RES: w = '{a & ~mask, 1'b1, zi, ni, hi, ci};
            hcalu_pkg::OP_SET: w = '{a | mask, 1'b1, zi, ni, hi, ci};
            hcalu_pkg::OP_DAA: begin
                // adjust tests look at the original byte, not the partial sum
                r = a;
                c = ci;
                if (!ni) begin
                    if (ci || a > hcalu_pkg::DAA_HI_MAX) begin
                        r = r + hcalu_pkg::DAA_HI_ADJ;
                        c = 1'b1;
                    end
                    if (hi || a[3:0] > hcalu_pkg::DAA_LO_MAX) r = r + hcalu_pkg::DAA_LO_ADJ;
                end else begin
                    if (ci) r = r - hcalu_pkg::DAA_HI_ADJ;
                    if (hi) r = r - hcalu_pkg::DAA_LO_ADJ;
                end
                w = '{r, 1'b1, r == 8'd0, ni, 1'b0, c};
            end
            hcalu_pkg::OP_CPL: w = '{~a, 1'b1, zi, 1'b1, 1'b1, ci};
            hcalu_pkg::OP_SCF: w = '{a, 1'b0, zi, 1'b0, 1'b0, 1'b1};
            hcalu_pkg::OP_CCF: w = '{a, 1'b0, zi, 1'b0, 1'b0, ~ci};
            default: ;
        endcase
        return w;
    endfunction

    // Report one field that differs from its prediction
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Retire strobed results against the oldest prediction, then queue new words
    always @(posedge i_clk) begin
        t_alu_word exp_w;
        if (i_rst_n) begin
            if (i_valid) begin
                if (alu_expected_q.size() == 0) begin
                    $error("result word 0x%0h strobed with no command word pending",
                           i_result);
                    mismatch_count++;
                end else begin
                    exp_w = alu_expected_q.pop_front();
                    check_field("result", exp_w.result, i_result);
                    check_field("writes_result", exp_w.wb, i_writes_result);
                    check_field("zero_out", exp_w.z, i_zero_out);
                    check_field("subtract_out", exp_w.n, i_subtract_out);
                    check_field("half_out", exp_w.h, i_half_out);
                    check_field("carry_out", exp_w.c, i_carry_out);
                end
            end
            if (i_start && !i_busy) begin
                alu_expected_q.push_back(predict_alu(i_cmd, i_operand_a, i_operand_b,
                    i_bit_index, i_zero_in, i_subtract_in, i_half_in, i_carry_in));
            end
        end
        o_pending <= alu_expected_q.size();
    end

endmodule

// File: test/handheld_cpu_alu_with_flags_unit_test.sv
// Top of the handheld CPU ALU regression: clock, reset and command stimulus.
// Depends on hcalu_pkg, the ALU top level and handheld_cpu_alu_with_flags_unit_checker.
module handheld_cpu_alu_with_flags_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [4:0] i_cmd;
    logic [7:0] i_operand_a;
    logic [7:0] i_operand_b;
    logic [2:0] i_bit_index;
    logic       i_zero_in;
    logic       i_subtract_in;
    logic       i_half_in;
    logic       i_carry_in;
    logic       o_valid;
    logic [7:0] o_result;
    logic       o_writes_result;
    logic       o_zero_out;
    logic       o_subtract_out;
    logic       o_half_out;
    logic       o_carry_out;
    int         fail_count;
    int         pending_count;
    int         cycle_count = 0;
    int         words_sent  = 0;
    bit         burst_mode  = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    handheld_cpu_alu_with_flags_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_bit_index    (i_bit_index),
        .i_zero_in      (i_zero_in),
        .i_subtract_in  (i_subtract_in),
        .i_half_in      (i_half_in),
        .i_carry_in     (i_carry_in),
        .o_valid        (o_valid),
        .o_result       (o_result),
        .o_writes_result(o_writes_result),
        .o_zero_out     (o_zero_out),
        .o_subtract_out (o_subtract_out),
        .o_half_out     (o_half_out),
        .o_carry_out    (o_carry_out)
    );

    handheld_cpu_alu_with_flags_unit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (i_cmd),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_bit_index    (i_bit_index),
        .i_zero_in      (i_zero_in),
        .i_subtract_in  (i_subtract_in),
        .i_half_in      (i_half_in),
        .i_carry_in     (i_carry_in),
        .i_valid        (o_valid),
        .i_result       (o_result),
        .i_writes_result(o_writes_result),
        .i_zero_out     (o_zero_out),
        .i_subtract_out (o_subtract_out),
        .i_half_out     (o_half_out),
        .i_carry_out    (o_carry_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    // Drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("handheld_cpu_alu_with_flags_unit regression: fail");
            $finish;
        end
    end

    // Outside burst mode, idle start for a drawn number of cycles; then present
    // one word and hold it until taken; returns at the edge that accepts it
    task automatic send_word(input logic [4:0] cmd, input logic [7:0] a,
                             input logic [7:0] b, input logic [2:0] bi,
                             input logic [3:0] znhc);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_operand_a   <= a;
        i_operand_b   <= b;
        i_bit_index   <= bi;
        i_zero_in     <= znhc[3];
        i_subtract_in <= znhc[2];
        i_half_in     <= znhc[1];
        i_carry_in    <= znhc[0];
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Bias operands toward nibble and byte boundaries
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return {4'($urandom_range(0, 15)), 4'hF};
            3: return {4'($urandom_range(0, 15)), 4'h0};
            4: return 8'($urandom_range(8'h90, 8'h9F));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cmd         <= '0;
        i_operand_a   <= '0;
        i_operand_b   <= '0;
        i_bit_index   <= '0;
        i_zero_in     <= 1'b0;
        i_subtract_in <= 1'b0;
        i_half_in     <= 1'b0;
        i_carry_in    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every defined code at least once, at carry, borrow and zero boundaries
        send_word(hcalu_pkg::OP_ADD,  8'hFF, 8'h01, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_ADC,  8'h0F, 8'hF0, 3'd0, 4'b0001);
        send_word(hcalu_pkg::OP_SUB,  8'h00, 8'h01, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_SBC,  8'h10, 8'h0F, 3'd0, 4'b0001);
        send_word(hcalu_pkg::OP_AND,  8'hFF, 8'h00, 3'd0, 4'b0101);
        send_word(hcalu_pkg::OP_XOR,  8'hAA, 8'hAA, 3'd0, 4'b0111);
        send_word(hcalu_pkg::OP_OR,   8'h00, 8'h00, 3'd0, 4'b0011);
        send_word(hcalu_pkg::OP_CP,   8'h3C, 8'h3C, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_INC,  8'hFF, 8'h00, 3'd0, 4'b0001);
        send_word(hcalu_pkg::OP_DEC,  8'h10, 8'h00, 3'd0, 4'b1000);
        send_word(hcalu_pkg::OP_RLC,  8'h00, 8'h00, 3'd0, 4'b0001);
        send_word(hcalu_pkg::OP_RRC,  8'h01, 8'h00, 3'd0, 4'b1110);
        send_word(hcalu_pkg::OP_RL,   8'h80, 8'h00, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_RR,   8'h01, 8'hFF, 3'd0, 4'b1111);
        send_word(hcalu_pkg::OP_SLA,  8'h80, 8'h00, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_SRA,  8'h81, 8'h00, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_SWAP, 8'hF0, 8'h00, 3'd0, 4'b1111);
        send_word(hcalu_pkg::OP_SRL,  8'h01, 8'h00, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_BIT,  8'h7F, 8'h00, 3'd7, 4'b0001);
        send_word(hcalu_pkg::OP_RES,  8'hFF, 8'h00, 3'd0, 4'b1010);
        send_word(hcalu_pkg::OP_SET,  8'h00, 8'h00, 3'd7, 4'b0101);
        send_word(hcalu_pkg::OP_DAA,  8'h9A, 8'h00, 3'd0, 4'b0000);
        send_word(hcalu_pkg::OP_DAA,  8'h00, 8'h00, 3'd0, 4'b0111);
        send_word(hcalu_pkg::OP_CPL,  8'hFF, 8'h00, 3'd0, 4'b1000);
        send_word(hcalu_pkg::OP_SCF,  8'h5A, 8'h00, 3'd0, 4'b1110);
        send_word(hcalu_pkg::OP_CCF,  8'hA5, 8'h00, 3'd0, 4'b1111);
        // accumulator rotates clear Z even when the byte rotates to zero
        send_word(hcalu_pkg::OP_RLCA, 8'h00, 8'h00, 3'd0, 4'b1000);
        send_word(hcalu_pkg::OP_RRCA, 8'h01, 8'h00, 3'd0, 4'b1000);
        send_word(hcalu_pkg::OP_RLA,  8'h80, 8'h00, 3'd0, 4'b1000);
        send_word(hcalu_pkg::OP_RRA,  8'h01, 8'h00, 3'd0, 4'b1000);
        // unused codes pass everything through
        send_word(5'd29,   8'hC3, 8'h00, 3'd0, 4'b1111);
        send_word(5'd31,   8'h3C, 8'hFF, 3'd7, 4'b0000);
        wait_drained();

        // Random: full code space, biased operands, bursts without idling
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_WORDS / 2) wait_drained();
            send_word(5'($urandom_range(0, 31)), pick_byte(), pick_byte(),
                      3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        end

        // Drain, then let the pipeline settle before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d command words over all 32 operation codes,", words_sent);
        $display("boundary operands, random flags and random sender gaps.");
        if (fail_count == 0) begin
            $display("handheld_cpu_alu_with_flags_unit regression: pass");
        end else begin
            $display("handheld_cpu_alu_with_flags_unit regression: fail");
        end
        $finish;
    end

endmodule
